@@ rtl/qtl_pkg.sv @@
// Package for the quoted token lexer: byte codes, the status code type and
// the structs passed between the lexer step logic and the top level.
// No dependencies.
package qtl_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ESCAPE = 2'd1,
    STATUS_QUOTE  = 2'd2
  } status_e;

  typedef struct packed {
    logic escape_pending;
    logic inside_quotes;
    logic token_open;
  } lex_state_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       end_of_text;
  } lex_in_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       token_end;
    logic       text_done;
    status_e    status;
  } lex_res_t;

endpackage

@@ rtl/quoted_token_lexer_unit.sv @@
// Top level of the quoted token lexer: input register, lexer state flags,
// result register and the valid/stall flow control around them.
// Depends on qtl_pkg and qtl_step.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------
//   input   | in        | in_valid_i, in_stall_o | text_byte_i, has_byte_i,
//           |           |                        | end_of_text_i
//   result  | out       | res_valid_o,           | out_valid_o, out_byte_o,
//           |           | res_stall_i            | token_end_o, text_done_o, status_o
//
// One word is accepted per cycle while in_stall_o is low, and one result word is
// given for each input word. A word is held in the input register, and its
// result is loaded into the result register when the word moves on.
// The three state flags are updated in the cycle a word moves from the input
// register into the result register, so the following word sees them at once.
// Reset clears both valid flags and the state flags.
// A stall on the result side holds the result register; the input register
// still takes a word while it is empty, and in_stall_o rises only when both
// registers hold a word and the result cannot move.
module quoted_token_lexer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       has_byte_i,
  input  logic       end_of_text_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       token_end_o,
  output logic       text_done_o,
  output logic [1:0] status_o
);
  import qtl_pkg::*;

  lex_in_t    in_q;
  logic       in_valid_q;
  lex_state_t state_q;
  lex_state_t state_d;
  lex_res_t   res_q;
  lex_res_t   res_d;
  logic       res_valid_q;

  // The result register can load when it is empty or is being taken.
  logic res_en;
  // The word in the input register moves into the result register.
  logic advance;
  // A new word enters the input register.
  logic in_take;

  assign res_en     = !res_valid_q || !res_stall_i;
  assign advance    = in_valid_q && res_en;
  assign in_stall_o = in_valid_q && !res_en;
  assign in_take    = in_valid_i && !in_stall_o;

  qtl_step u_step (
    .in_i    (in_q),
    .state_i (state_q),
    .res_o   (res_d),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (res_en) begin
        res_valid_q <= in_valid_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers carry no reset; their valid flags guard them.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.text_byte   <= text_byte_i;
      in_q.has_byte    <= has_byte_i;
      in_q.end_of_text <= end_of_text_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign out_valid_o = res_q.out_valid;
  assign out_byte_o  = res_q.out_byte;
  assign token_end_o = res_q.token_end;
  assign text_done_o = res_q.text_done;
  assign status_o    = res_q.status;

`ifndef ASSERT_OFF
  // The state flags return to reset after an end-of-text word is processed.
  a_eot_clears_state : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.end_of_text) |=> (state_q == '0)
  ) else $error("lexer state not cleared after end of text");

  // An error status only comes with the end-of-text mark and never with a token end.
  a_status_on_done : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.status != STATUS_OK)) |-> (res_q.text_done && !res_q.token_end)
  ) else $error("error status outside an end-of-text result");

  // A held word in the input register is not dropped.
  a_in_word_kept : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q
  ) else $error("input word lost while the result side stalled");
`endif

endmodule

@@ rtl/qtl_step.sv @@
// Combinational lexer step: one input word and the current state give one
// result and the next state.
// Depends on qtl_pkg.
module qtl_step (
  input  qtl_pkg::lex_in_t    in_i,
  input  qtl_pkg::lex_state_t state_i,
  output qtl_pkg::lex_res_t   res_o,
  output qtl_pkg::lex_state_t state_o
);
  import qtl_pkg::*;

  function automatic logic [7:0] translate_escape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      CH_LOW_N: r = CH_LF;
      CH_LOW_R: r = CH_CR;
      CH_LOW_T: r = CH_TAB;
      CH_ZERO:  r = 8'h00;
      default:  r = b;
    endcase
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    logic r;
    case (b) inside
      CH_SPACE, CH_TAB, CH_LF, CH_CR: r = 1'b1;
      default:                        r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    res_o   = '0;
    state_o = state_i;

    if (in_i.has_byte) begin
      if (state_i.escape_pending) begin
        res_o.out_valid        = 1'b1;
        res_o.out_byte         = translate_escape(in_i.text_byte);
        state_o.escape_pending = 1'b0;
      end else if (in_i.text_byte == CH_BSLASH) begin
        state_o.escape_pending = 1'b1;
      end else if (state_i.inside_quotes) begin
        if (in_i.text_byte == CH_QUOTE) begin
          // A closing quote ends the token even when it is empty.
          res_o.token_end       = 1'b1;
          state_o.inside_quotes = 1'b0;
          state_o.token_open    = 1'b0;
        end else begin
          res_o.out_valid = 1'b1;
          res_o.out_byte  = in_i.text_byte;
        end
      end else if (in_i.text_byte == CH_QUOTE) begin
        res_o.token_end       = state_i.token_open;
        state_o.token_open    = 1'b0;
        state_o.inside_quotes = 1'b1;
      end else if (is_space(in_i.text_byte)) begin
        res_o.token_end    = state_i.token_open;
        state_o.token_open = 1'b0;
      end else begin
        res_o.out_valid = 1'b1;
        res_o.out_byte  = in_i.text_byte;
      end
      if (res_o.out_valid) begin
        state_o.token_open = 1'b1;
      end
    end

    if (in_i.end_of_text) begin
      res_o.text_done = 1'b1;
      if (state_o.escape_pending) begin
        res_o.status    = STATUS_ESCAPE;
        res_o.token_end = 1'b0;
      end else if (state_o.inside_quotes) begin
        res_o.status    = STATUS_QUOTE;
        res_o.token_end = 1'b0;
      end else if (state_o.token_open) begin
        res_o.token_end = 1'b1;
      end
      state_o = '0;
    end
  end

endmodule

@@ dv/quoted_token_lexer_checker.sv @@
`timescale 1ns / 1ps
// Result checker for quoted_token_lexer_unit: predicts each result word from
// the accepted input words and compares it with the word the block returns.
// Depends on qtl_pkg.
module quoted_token_lexer_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] text_byte_i,
  input  logic       has_byte_i,
  input  logic       end_of_text_i,
  input  logic       res_valid_i,
  input  logic       res_stall_i,
  input  logic       out_valid_i,
  input  logic [7:0] out_byte_i,
  input  logic       token_end_i,
  input  logic       text_done_i,
  input  logic [1:0] status_i,
  output int         mismatch_count_o,
  output int         pending_count_o
);
  import qtl_pkg::*;

  lex_res_t   token_results_q[$];
  lex_state_t lexer_flags;
  lex_state_t lexer_flags_next;
  lex_in_t    text_word;
  lex_res_t   wanted;
  int         mismatches;

  // Works out the result word for one text word and the flags that follow it.
  function automatic lex_res_t predict_lexer_result(input lex_in_t w, input lex_state_t cur,
                                                    output lex_state_t nxt);
    lex_res_t   r;
    lex_state_t s;
    r = '0;
    r.status = STATUS_OK;
    s = cur;
    if (w.has_byte) begin
      if (s.escape_pending) begin
        r.out_valid = 1'b1;
        case (w.text_byte)
          CH_LOW_N: r.out_byte = CH_LF;
          CH_LOW_R: r.out_byte = CH_CR;
          CH_LOW_T: r.out_byte = CH_TAB;
          CH_ZERO:  r.out_byte = 8'h00;
          default:  r.out_byte = w.text_byte;
        endcase
        s.escape_pending = 1'b0;
      end else if (w.text_byte == CH_BSLASH) begin
        s.escape_pending = 1'b1;
      end else if (s.inside_quotes) begin
        if (w.text_byte == CH_QUOTE) begin
          r.token_end     = 1'b1;
          s.inside_quotes = 1'b0;
          s.token_open    = 1'b0;
        end else begin
          r.out_valid = 1'b1;
          r.out_byte  = w.text_byte;
        end
      end else if (w.text_byte == CH_QUOTE) begin
        r.token_end     = s.token_open;
        s.token_open    = 1'b0;
        s.inside_quotes = 1'b1;
      end else if (w.text_byte == CH_SPACE || w.text_byte == CH_TAB ||
                   w.text_byte == CH_LF || w.text_byte == CH_CR) begin
        r.token_end  = s.token_open;
        s.token_open = 1'b0;
      end else begin
        r.out_valid = 1'b1;
        r.out_byte  = w.text_byte;
      end
      if (r.out_valid) s.token_open = 1'b1;
    end
    if (w.end_of_text) begin
      r.text_done = 1'b1;
      if (s.escape_pending) begin
        r.status    = STATUS_ESCAPE;
        r.token_end = 1'b0;
      end else if (s.inside_quotes) begin
        r.status    = STATUS_QUOTE;
        r.token_end = 1'b0;
      end else if (s.token_open) begin
        r.token_end = 1'b1;
      end
      s = '0;
    end
    nxt = s;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_results_q.delete();
      lexer_flags = '0;
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_count_o <= 0;
    end else begin
      // Results are handled first: a word accepted at this edge cannot yet have
      // its result on the output side.
      if (res_valid_i && !res_stall_i) begin
        if (token_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: result word with nothing expected: valid=%0b byte=%h end=%0b done=%0b status=%0d",
                     $time, out_valid_i, out_byte_i, token_end_i, text_done_i, status_i);
        end else begin
          wanted = token_results_q.pop_front();
          if (out_valid_i !== wanted.out_valid || out_byte_i !== wanted.out_byte ||
              token_end_i !== wanted.token_end || text_done_i !== wanted.text_done ||
              status_i !== wanted.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t: result word differs: expected valid=%0b byte=%h end=%0b done=%0b status=%0d, got valid=%0b byte=%h end=%0b done=%0b status=%0d",
                       $time, wanted.out_valid, wanted.out_byte, wanted.token_end,
                       wanted.text_done, wanted.status, out_valid_i, out_byte_i,
                       token_end_i, text_done_i, status_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        text_word.text_byte   = text_byte_i;
        text_word.has_byte    = has_byte_i;
        text_word.end_of_text = end_of_text_i;
        token_results_q.push_back(predict_lexer_result(text_word, lexer_flags, lexer_flags_next));
        lexer_flags = lexer_flags_next;
      end
      mismatch_count_o <= mismatches;
      pending_count_o <= token_results_q.size();
    end
  end

endmodule

@@ dv/quoted_token_lexer_unit_test.sv @@
`timescale 1ns / 1ps
// Testbench top for quoted_token_lexer_unit: drives text words, stalls the
// result side at random and gives the verdict.
// Depends on qtl_pkg, quoted_token_lexer_unit and quoted_token_lexer_checker.
module quoted_token_lexer_unit_test;
  import qtl_pkg::*;

  // The watchdog allows this many cycles in which neither channel moves a word.
  // Legal quiet stretches are a sender gap plus a receiver stall, well below it.
  localparam int IdleLimit = 500;
  localparam int TextWordGoal = 1500;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] text_byte_i = 8'h00;
  logic       has_byte_i = 1'b0;
  logic       end_of_text_i = 1'b0;
  logic       res_valid_o;
  logic       res_stall_i = 1'b0;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       token_end_o;
  logic       text_done_o;
  logic [1:0] status_o;

  int mismatch_count;
  int pending_count;
  int idle_cycles;
  int words_sent;
  int sender_max_gap;

  quoted_token_lexer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .has_byte_i    (has_byte_i),
    .end_of_text_i (end_of_text_i),
    .res_valid_o   (res_valid_o),
    .res_stall_i   (res_stall_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .token_end_o   (token_end_o),
    .text_done_o   (text_done_o),
    .status_o      (status_o)
  );

  // The checker watches both channels and owns all prediction; the top only
  // reads back how many result words are still owed and how many were wrong.
  quoted_token_lexer_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .text_byte_i      (text_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_text_i    (end_of_text_i),
    .res_valid_i      (res_valid_o),
    .res_stall_i      (res_stall_i),
    .out_valid_i      (out_valid_o),
    .out_byte_i       (out_byte_o),
    .token_end_i      (token_end_o),
    .text_done_i      (text_done_o),
    .status_i         (status_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Offers one word after a random gap and returns at the edge that takes it.
  // The stall is looked at on the falling edge, where it is settled, so the
  // decision never races the rising edge. Valid stays high straight into the
  // next word when no gap is drawn, so it is never dropped and raised in one step.
  task automatic send_word(input logic [7:0] text_byte, input logic has_byte,
                           input logic end_of_text);
    int gap;
    gap = $urandom_range(0, sender_max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    text_byte_i <= text_byte;
    has_byte_i <= has_byte;
    end_of_text_i <= end_of_text;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    if (has_byte || end_of_text) words_sent++;
  endtask

  // Holds the sender off until every result word owed so far has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    @(posedge clk_i);
  endtask

  // Result side: before each word a random number of stall cycles, drawn from
  // a range that switches now and then between none at all and up to six.
  initial begin
    int hold;
    int max_hold;
    int taken;
    taken = 0;
    max_hold = 6;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken % 50 == 0) max_hold = ($urandom_range(0, 2) == 0) ? 0 : 6;
      hold = $urandom_range(0, max_hold);
      if (hold > 0) begin
        res_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        res_stall_i <= 1'b0;
      end
      do @(negedge clk_i); while (!res_valid_o);
      @(posedge clk_i);
      taken++;
    end
  end

  // Watchdog: a stretch with no word moving on either channel means a hang.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (res_valid_o && !res_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%t: no word moved for %0d cycles", $time, IdleLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int len;
    int kind;
    int next_drain;
    logic [7:0] text_byte;
    logic has_byte;
    logic end_of_text;
    words_sent = 0;
    sender_max_gap = 6;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Plain bytes and each whitespace byte; the zero byte and
    // the all-ones byte are ordinary token bytes.
    send_word("a", 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(CH_SPACE, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(CH_TAB, 1'b1, 1'b0);
    send_word("b", 1'b1, 1'b0);
    send_word(CH_LF, 1'b1, 1'b0);
    send_word("c", 1'b1, 1'b0);
    send_word(CH_CR, 1'b1, 1'b0);
    // A translated escape, then an escaped byte that passes as it is.
    send_word(CH_BSLASH, 1'b1, 1'b0);
    send_word(CH_LOW_N, 1'b1, 1'b0);
    send_word(CH_BSLASH, 1'b1, 1'b0);
    send_word(8'hA7, 1'b1, 1'b0);
    // The opening quote ends the open token; closing it at once still gives a
    // token end for the empty quoted token.
    send_word(CH_QUOTE, 1'b1, 1'b0);
    send_word(CH_QUOTE, 1'b1, 1'b0);
    // An empty word leaves the flags alone.
    send_word(8'h5A, 1'b0, 1'b0);
    // An escaped quote inside quotes, then the text ends with the quote open.
    send_word(CH_QUOTE, 1'b1, 1'b0);
    send_word(CH_BSLASH, 1'b1, 1'b0);
    send_word(CH_QUOTE, 1'b1, 1'b1);
    // A backslash on the end word itself leaves a dangling escape.
    send_word(CH_BSLASH, 1'b1, 1'b1);
    // An end-only word closes the open token.
    send_word("q", 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    // Dangling escape inside an open quote: the escape error wins.
    send_word(CH_QUOTE, 1'b1, 1'b0);
    send_word(CH_BSLASH, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    // A byte and the end of text in the same word.
    send_word("z", 1'b1, 1'b1);
    wait_for_drain();

    // Random part: short texts in which backslashes, quotes and whitespace make up
    // about a third of the bytes and escape letters, placed at random, a tenth.
    // About one text in ten runs on into the next without an end.
    next_drain = 500;
    while (words_sent < TextWordGoal) begin
      len = $urandom_range(1, 16);
      sender_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
      for (int i = 0; i < len; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 10) text_byte = CH_BSLASH;
        else if (kind < 20) text_byte = CH_QUOTE;
        else if (kind < 24) text_byte = CH_SPACE;
        else if (kind < 27) text_byte = CH_TAB;
        else if (kind < 29) text_byte = CH_LF;
        else if (kind < 31) text_byte = CH_CR;
        else if (kind < 41) begin
          case ($urandom_range(0, 3))
            0: text_byte = CH_LOW_N;
            1: text_byte = CH_LOW_R;
            2: text_byte = CH_LOW_T;
            default: text_byte = CH_ZERO;
          endcase
        end else if (kind < 56) text_byte = 8'($urandom_range(0, 255));
        else text_byte = 8'("a" + $urandom_range(0, 25));
        has_byte = ($urandom_range(0, 19) != 0);
        end_of_text = (i == len - 1) && ($urandom_range(0, 9) != 0);
        send_word(text_byte, has_byte, end_of_text);
      end
      if (words_sent >= next_drain) begin
        wait_for_drain();
        next_drain += 500;
      end
    end

    wait_for_drain();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
